>>> hw/rtl/rpr_pkg.sv
// Shared types and constants for the reprojection residual pipeline.
package rpr_pkg;

  localparam int QW    = 32;
  localparam int CW    = 100;
  localparam int NW    = 132;
  localparam int NUMW  = 133;
  localparam int ADW   = 99;
  localparam int LIMB  = 25;
  localparam int NLIMB = 4;
  localparam int PPW   = 60;

  localparam logic [30:0] FOCAL_RESET = 31'd32768000;
  localparam logic [31:0] RES_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] RES_MIN     = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_FOCAL_X,
    CFG_FOCAL_Y,
    CFG_PRINCIPAL_X,
    CFG_PRINCIPAL_Y
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] obs_x;
    logic signed [31:0] obs_y;
  } rpr_in_t;

  typedef struct packed {
    logic signed [31:0] residual_x;
    logic signed [31:0] residual_y;
    logic               depth_zero;
    logic               saturated;
  } rpr_out_t;

  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [NUMW-1:0] den;
    logic            neg;
    logic            big;
    logic            fneg;
  } rpr_lane_t;

endpackage

>>> hw/rtl/rpr_div.sv
// Pipelined restoring divider for both residual lanes, with sign, zero-depth and saturation handling.
module rpr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic                      in_dz,
  input  rpr_pkg::rpr_lane_t [1:0]  in_lane,
  output logic                      out_valid,
  output rpr_pkg::rpr_out_t         out_res
);
  import rpr_pkg::*;

  logic [QW:1]     v;
  logic [QW:1]     dz;
  rpr_lane_t       lane      [1:QW][2];
  logic [QW-1:0]   quo       [1:QW][2];
  rpr_lane_t       lane_next [1:QW][2];
  logic [QW-1:0]   quo_next  [1:QW][2];
  logic [NUMW:0]   r;
  logic [31:0]     res_r [2];
  logic            big_any;

  function automatic logic [NUMW:0] div_step(input logic [NUMW-1:0] rem,
                                             input logic [NUMW-1:0] den,
                                             input int k);
    logic [NUMW-1:0] sh;
    logic [NUMW:0]   d;
    sh = den << k;
    d  = {1'b0, rem} - {1'b0, sh};
    return d[NUMW] ? {1'b0, rem} : {1'b1, d[NUMW-1:0]};
  endfunction

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r = div_step(in_lane[l].num, in_lane[l].den, QW - 1);
      lane_next[1][l] = in_lane[l];
      lane_next[1][l].num = r[NUMW-1:0];
      quo_next[1][l] = '0;
      quo_next[1][l][QW-1] = r[NUMW];
      for (int s = 2; s <= QW; s++) begin
        r = div_step(lane[s-1][l].num, lane[s-1][l].den, QW - s);
        lane_next[s][l] = lane[s-1][l];
        lane_next[s][l].num = r[NUMW-1:0];
        quo_next[s][l] = quo[s-1][l];
        quo_next[s][l][QW-s] = r[NUMW];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dz[QW]) begin
        res_r[l] = lane[QW][l].fneg ? RES_MIN : RES_MAX;
      end else if (lane[QW][l].big) begin
        res_r[l] = lane[QW][l].neg ? RES_MIN : RES_MAX;
      end else begin
        res_r[l] = lane[QW][l].neg ? (32'd0 - quo[QW][l]) : quo[QW][l];
      end
    end
    big_any = !dz[QW] && (lane[QW][0].big || lane[QW][1].big);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[QW-1:1], in_valid};
      out_valid <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz <= {dz[QW-1:1], in_dz};
      for (int s = 1; s <= QW; s++) begin
        for (int l = 0; l < 2; l++) begin
          lane[s][l] <= lane_next[s][l];
          quo[s][l]  <= quo_next[s][l];
        end
      end
      out_res.residual_x <= res_r[0];
      out_res.residual_y <= res_r[1];
      out_res.depth_zero <= dz[QW];
      out_res.saturated  <= dz[QW] | big_any;
    end
  end

  a_dz_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.depth_zero |-> out_res.saturated)
    else $error("zero depth beat without saturation");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid))
    else $error("divider moved while held");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    en && v[QW] |=> out_valid)
    else $error("divider lost a beat");

  a_rem_x: assert property (@(posedge clk) disable iff (rst)
    v[QW] && !dz[QW] && !lane[QW][0].big |-> lane[QW][0].num < lane[QW][0].den)
    else $error("x remainder not reduced");

  a_rem_y: assert property (@(posedge clk) disable iff (rst)
    v[QW] && !dz[QW] && !lane[QW][1].big |-> lane[QW][1].num < lane[QW][1].den)
    else $error("y remainder not reduced");

endmodule

>>> hw/rtl/reprojection_residual.sv
// Top level: pinhole reprojection residual with quaternion pose, fully pipelined.
//
// Input channel obs_valid/obs_stall/obs carries one observation per beat:
// quaternion (Q2.30), translation, world point and observed pixel (Q16.16).
// Output channel res_valid/res_stall/res carries one result beat per
// observation, in order: residuals in Q16.16, zero-depth and saturation flags.
// Configuration writes (cfg_we, cfg_index, cfg_data) set focal lengths and
// principal point; write them only while the pipeline is empty.
// Throughput: one observation per cycle while obs_stall is low. Pipeline:
// 12 arithmetic stages (products, rotation, projection numerator, abs and
// saturation bound), then one restoring-divider stage per quotient bit (32)
// and two output registers.
// Reset clears all valid bits and loads focal 500.0 and principal point 0.
// When the receiver stalls, the result waits in the output register and one
// more beat is parked in a skid register; only then does obs_stall rise and
// the whole pipeline hold, losing nothing.
module reprojection_residual (
  input  logic              clk,
  input  logic              rst,
  input  logic              obs_valid,
  output logic              obs_stall,
  input  rpr_pkg::rpr_in_t  obs,
  output logic              res_valid,
  input  logic              res_stall,
  output rpr_pkg::rpr_out_t res,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import rpr_pkg::*;

  logic [30:0]        focal_x;
  logic [30:0]        focal_y;
  logic signed [31:0] principal_x;
  logic signed [31:0] principal_y;
  logic [30:0]        focal [2];

  logic        adv;
  logic [12:1] fv;

  logic signed [63:0] s1_aa, s1_bb, s1_cc, s1_dd, s1_ab, s1_ac, s1_ad, s1_bc, s1_bd, s1_cd;
  logic signed [31:0] s1_p [3];
  logic signed [32:0] s1_pt [3];
  logic signed [32:0] s1_co [2];

  logic signed [65:0] s2_n;
  logic signed [65:0] s2_m [9];
  logic signed [31:0] s2_p [3];
  logic signed [32:0] s2_pt [3];
  logic signed [32:0] s2_co [2];

  logic signed [65:0] s3_mlo [9];
  logic signed [65:0] s3_mhi [9];
  logic signed [66:0] s3_nlo [3];
  logic signed [66:0] s3_nhi [3];
  logic signed [32:0] s3_co [2];

  logic signed [CW-1:0] s4_prod [9];
  logic signed [CW-1:0] s4_npt [3];
  logic signed [32:0]   s4_co [2];

  logic signed [CW-1:0] s5_cam [3];
  logic signed [32:0]   s5_co [2];
  logic signed [LIMB:0] s5_lmb [3][NLIMB];

  logic signed [PPW-1:0] s6_fpp [2][NLIMB];
  logic signed [PPW-1:0] s6_cpp [2][NLIMB];
  logic                  s6_dz, s6_zneg;
  logic [ADW-1:0]        s6_ad;
  logic signed [NW-1:0]  fsum [2];
  logic signed [NW-1:0]  csum [2];

  logic signed [NW-1:0] s7_fnum [2];
  logic signed [NW-1:0] s7_conum [2];
  logic                 s7_dz, s7_zneg;
  logic [ADW-1:0]       s7_ad;

  logic signed [NW-1:0] s8_num [2];
  logic                 s8_fneg [2];
  logic                 s8_dz, s8_zneg;
  logic [ADW-1:0]       s8_ad;

  logic [NW-2:0]  s9_an [2];
  logic           s9_neg [2];
  logic           s9_fneg [2];
  logic           s9_dz;
  logic [ADW-1:0] s9_ad;

  logic [NUMW-1:0] s10_num [2];
  logic [NUMW-1:0] s10_den;
  logic            s10_neg [2];
  logic            s10_fneg [2];
  logic            s10_dz;

  logic [NUMW-1:0] s11_num [2];
  logic [NUMW-1:0] s11_thr [2];
  logic [NUMW-1:0] s11_den;
  logic            s11_neg [2];
  logic            s11_fneg [2];
  logic            s11_dz;

  rpr_lane_t [1:0] s12_lane;
  logic            s12_dz;

  logic     p_valid;
  rpr_out_t p_res;
  logic     skid_v;
  rpr_out_t skid;
  logic     load_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x     <= FOCAL_RESET;
      focal_y     <= FOCAL_RESET;
      principal_x <= '0;
      principal_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCAL_X:     focal_x     <= cfg_data[30:0];
        CFG_FOCAL_Y:     focal_y     <= cfg_data[30:0];
        CFG_PRINCIPAL_X: principal_x <= $signed(cfg_data);
        CFG_PRINCIPAL_Y: principal_y <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    focal[0] = focal_x;
    focal[1] = focal_y;
  end

  assign adv       = !skid_v;
  assign obs_stall = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (adv) begin
      fv <= {fv[11:1], obs_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < NLIMB; k++) begin
        if (k == NLIMB - 1) begin
          s5_lmb[i][k] = (LIMB + 1)'($signed(s5_cam[i][k*LIMB +: LIMB]));
        end else begin
          s5_lmb[i][k] = $signed({1'b0, s5_cam[i][k*LIMB +: LIMB]});
        end
      end
    end
    for (int l = 0; l < 2; l++) begin
      fsum[l] = '0;
      csum[l] = '0;
      for (int k = 0; k < NLIMB; k++) begin
        fsum[l] = fsum[l] + (NW'(s6_fpp[l][k]) <<< (LIMB * k));
        csum[l] = csum[l] + (NW'(s6_cpp[l][k]) <<< (LIMB * k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_aa <= obs.quat_w * obs.quat_w;
      s1_bb <= obs.quat_x * obs.quat_x;
      s1_cc <= obs.quat_y * obs.quat_y;
      s1_dd <= obs.quat_z * obs.quat_z;
      s1_ab <= obs.quat_w * obs.quat_x;
      s1_ac <= obs.quat_w * obs.quat_y;
      s1_ad <= obs.quat_w * obs.quat_z;
      s1_bc <= obs.quat_x * obs.quat_y;
      s1_bd <= obs.quat_x * obs.quat_z;
      s1_cd <= obs.quat_y * obs.quat_z;
      s1_p[0]  <= obs.point_x;
      s1_p[1]  <= obs.point_y;
      s1_p[2]  <= obs.point_z;
      s1_pt[0] <= 33'(obs.point_x) + 33'(obs.trans_x);
      s1_pt[1] <= 33'(obs.point_y) + 33'(obs.trans_y);
      s1_pt[2] <= 33'(obs.point_z) + 33'(obs.trans_z);
      s1_co[0] <= 33'(principal_x) - 33'(obs.obs_x);
      s1_co[1] <= 33'(principal_y) - 33'(obs.obs_y);

      s2_n    <= 66'(s1_aa) + 66'(s1_bb) + 66'(s1_cc) + 66'(s1_dd);
      s2_m[0] <= -(66'(s1_cc) + 66'(s1_dd));
      s2_m[1] <= 66'(s1_bc) - 66'(s1_ad);
      s2_m[2] <= 66'(s1_ac) + 66'(s1_bd);
      s2_m[3] <= 66'(s1_ad) + 66'(s1_bc);
      s2_m[4] <= -(66'(s1_bb) + 66'(s1_dd));
      s2_m[5] <= 66'(s1_cd) - 66'(s1_ab);
      s2_m[6] <= 66'(s1_bd) - 66'(s1_ac);
      s2_m[7] <= 66'(s1_ab) + 66'(s1_cd);
      s2_m[8] <= -(66'(s1_bb) + 66'(s1_cc));
      s2_p  <= s1_p;
      s2_pt <= s1_pt;
      s2_co <= s1_co;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s3_mlo[3*i+j] <= $signed({1'b0, s2_m[3*i+j][32:0]}) * s2_p[j];
          s3_mhi[3*i+j] <= $signed(s2_m[3*i+j][65:33]) * s2_p[j];
        end
        s3_nlo[i] <= $signed({1'b0, s2_n[32:0]}) * s2_pt[i];
        s3_nhi[i] <= $signed(s2_n[65:33]) * s2_pt[i];
      end
      s3_co <= s2_co;

      for (int k = 0; k < 9; k++) begin
        s4_prod[k] <= (CW'(s3_mhi[k]) <<< 33) + CW'(s3_mlo[k]);
      end
      for (int i = 0; i < 3; i++) begin
        s4_npt[i] <= (CW'(s3_nhi[i]) <<< 33) + CW'(s3_nlo[i]);
      end
      s4_co <= s3_co;

      for (int i = 0; i < 3; i++) begin
        s5_cam[i] <= s4_npt[i]
                   + ((s4_prod[3*i] + s4_prod[3*i+1] + s4_prod[3*i+2]) <<< 1);
      end
      s5_co <= s4_co;

      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < NLIMB; k++) begin
          s6_fpp[l][k] <= $signed({1'b0, focal[l]}) * s5_lmb[l][k];
          s6_cpp[l][k] <= s5_co[l] * s5_lmb[2][k];
        end
      end
      s6_dz   <= (s5_cam[2] == '0);
      s6_zneg <= s5_cam[2][CW-1];
      s6_ad   <= ADW'(s5_cam[2][CW-1] ? -s5_cam[2] : s5_cam[2]);

      s7_fnum  <= fsum;
      s7_conum <= csum;
      s7_dz    <= s6_dz;
      s7_zneg  <= s6_zneg;
      s7_ad    <= s6_ad;

      for (int l = 0; l < 2; l++) begin
        s8_num[l]  <= s7_fnum[l] + s7_conum[l];
        s8_fneg[l] <= s7_fnum[l][NW-1];
      end
      s8_dz   <= s7_dz;
      s8_zneg <= s7_zneg;
      s8_ad   <= s7_ad;

      for (int l = 0; l < 2; l++) begin
        s9_neg[l] <= s8_num[l][NW-1] ^ s8_zneg;
        s9_an[l]  <= (NW - 1)'(s8_num[l][NW-1] ? -s8_num[l] : s8_num[l]);
      end
      s9_fneg <= s8_fneg;
      s9_dz   <= s8_dz;
      s9_ad   <= s8_ad;

      for (int l = 0; l < 2; l++) begin
        s10_num[l] <= NUMW'({s9_an[l], 1'b0}) + NUMW'(s9_ad);
      end
      s10_den  <= NUMW'({s9_ad, 1'b0});
      s10_neg  <= s9_neg;
      s10_fneg <= s9_fneg;
      s10_dz   <= s9_dz;

      for (int l = 0; l < 2; l++) begin
        s11_thr[l] <= (s10_den << (QW - 1)) + (s10_neg[l] ? s10_den : '0);
      end
      s11_num  <= s10_num;
      s11_den  <= s10_den;
      s11_neg  <= s10_neg;
      s11_fneg <= s10_fneg;
      s11_dz   <= s10_dz;

      for (int l = 0; l < 2; l++) begin
        s12_lane[l].num  <= s11_num[l];
        s12_lane[l].den  <= s11_den;
        s12_lane[l].neg  <= s11_neg[l];
        s12_lane[l].big  <= (s11_num[l] >= s11_thr[l]);
        s12_lane[l].fneg <= s11_fneg[l];
      end
      s12_dz <= s11_dz;
    end
  end

  rpr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (fv[12]),
    .in_dz     (s12_dz),
    .in_lane   (s12_lane),
    .out_valid (p_valid),
    .out_res   (p_res)
  );

  assign load_res = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (load_res) begin
      res_valid <= skid_v | p_valid;
      skid_v    <= 1'b0;
    end else if (p_valid && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res <= skid_v ? skid : p_res;
    end else if (p_valid && !skid_v) begin
      skid <= p_res;
    end
  end

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> res_valid)
    else $error("skid beat with empty output");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && skid_v |=> res_valid && !skid_v)
    else $error("skid beat not advanced");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_v && res_stall |=> skid_v)
    else $error("skid beat dropped");

endmodule

>>> tb/reprojection_residual_tb.sv
// Self-checking testbench for the reprojection residual pipeline, random stalls and config sweeps.
module reprojection_residual_tb;
  import rpr_pkg::*;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    rpr_in_t beat;
    int      gap;
  } obs_item_t;

  logic     clk;
  logic     rst;
  logic     obs_valid;
  logic     obs_stall;
  rpr_in_t  obs;
  logic     res_valid;
  logic     res_stall;
  rpr_out_t res;
  logic     cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  reprojection_residual dut (
    .clk(clk), .rst(rst),
    .obs_valid(obs_valid), .obs_stall(obs_stall), .obs(obs),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  obs_item_t   pending_obs[$];
  rpr_out_t    expected_res[$];
  logic [30:0] focal_x_q, focal_y_q;
  logic signed [31:0] center_x_q, center_y_q;
  int  mismatches = 0;
  int  obs_sent = 0;
  int  res_seen = 0;
  int  zero_depth_seen = 0;
  int  clipped_seen = 0;
  bit  calm = 0;
  bit  hold_req = 0;

  function automatic logic [31:0] pixel_error(wide_t f, wide_t cam_xy, wide_t cam_z,
                                              wide_t center, wide_t seen, inout bit sat);
    wide_t num;
    logic [191:0] an, ad, q, limit;
    bit neg;
    num = f * cam_xy + (center - seen) * cam_z;
    neg = num[191] ^ cam_z[191];
    an = num[191] ? -num : num;
    ad = cam_z[191] ? -cam_z : cam_z;
    q = (2 * an + ad) / (2 * ad);
    limit = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
    if (q > limit) begin
      sat = 1;
      return limit[31:0];
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic rpr_out_t project_obs(rpr_in_t o);
    wide_t a, b, c, d, n, fx, fy;
    wide_t p[3], t[3], cam[3], m[3][3];
    rpr_out_t r;
    bit sat;
    a = o.quat_w; b = o.quat_x; c = o.quat_y; d = o.quat_z;
    p[0] = o.point_x; p[1] = o.point_y; p[2] = o.point_z;
    t[0] = o.trans_x; t[1] = o.trans_y; t[2] = o.trans_z;
    fx = wide_t'({1'b0, focal_x_q});
    fy = wide_t'({1'b0, focal_y_q});
    sat = 0;
    n = a * a + b * b + c * c + d * d;
    m[0][0] = -(c * c + d * d); m[0][1] = b * c - a * d; m[0][2] = a * c + b * d;
    m[1][0] = a * d + b * c; m[1][1] = -(b * b + d * d); m[1][2] = c * d - a * b;
    m[2][0] = b * d - a * c; m[2][1] = a * b + c * d; m[2][2] = -(b * b + c * c);
    for (int i = 0; i < 3; i++)
      cam[i] = n * (p[i] + t[i]) + 2 * (m[i][0] * p[0] + m[i][1] * p[1] + m[i][2] * p[2]);
    r.depth_zero = (cam[2] == 0);
    if (r.depth_zero) begin
      r.residual_x = (fx * cam[0] < 0) ? RES_MIN : RES_MAX;
      r.residual_y = (fy * cam[1] < 0) ? RES_MIN : RES_MAX;
      sat = 1;
    end else begin
      r.residual_x = pixel_error(fx, cam[0], cam[2], center_x_q, o.obs_x, sat);
      r.residual_y = pixel_error(fy, cam[1], cam[2], center_y_q, o.obs_y, sat);
    end
    r.saturated = sat;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  int        gap_left;
  bit        staged;
  obs_item_t cur;
  always @(posedge clk) begin
    bit fire, nv;
    if (rst) begin
      obs_valid <= 0;
      staged = 0;
      gap_left = 0;
    end else begin
      fire = obs_valid && !obs_stall;
      if (fire) begin
        expected_res.push_back(project_obs(obs));
        obs_sent++;
      end
      nv = obs_valid && !fire;
      if (!nv) begin
        if (!staged && pending_obs.size() > 0) begin
          cur = pending_obs.pop_front();
          staged = 1;
          gap_left = cur.gap;
        end
        if (staged) begin
          if (gap_left == 0) begin
            obs <= cur.beat;
            nv = 1;
            staged = 0;
          end else begin
            gap_left--;
          end
        end
      end
      obs_valid <= nv;
    end
  end

  // monitor
  int stall_left = 0;
  int long_hold = 0;
  always @(posedge clk) begin
    rpr_out_t want;
    if (rst) begin
      res_stall <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        res_seen++;
        if (res.depth_zero) zero_depth_seen++;
        if (res.saturated) clipped_seen++;
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", res);
        end else begin
          want = expected_res.pop_front();
          if (res !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at result %0d: expected %p, got %p", res_seen, want, res);
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, 16);
      end
      if (hold_req) begin
        long_hold = 300;
        hold_req = 0;
      end
      if (long_hold > 0) begin
        long_hold--;
        res_stall <= 1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1;
      end else begin
        res_stall <= 0;
      end
    end
  end

  task automatic add_obs(rpr_in_t o);
    obs_item_t it;
    it.beat = o;
    it.gap = calm ? 0 : $urandom_range(0, 16);
    pending_obs.push_back(it);
  endtask

  task automatic drain();
    while (pending_obs.size() > 0 || staged || obs_valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_FOCAL_X:     focal_x_q = v[30:0];
      CFG_FOCAL_Y:     focal_y_q = v[30:0];
      CFG_PRINCIPAL_X: center_x_q = v;
      CFG_PRINCIPAL_Y: center_y_q = v;
    endcase
  endtask

  function automatic rpr_in_t wild_obs();
    rpr_in_t o;
    o = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return o;
  endfunction

  function automatic logic signed [31:0] near(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic rpr_in_t scene_obs();
    rpr_in_t o;
    o.quat_w = $urandom;
    o.quat_x = $urandom;
    o.quat_y = $urandom;
    o.quat_z = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      o.quat_w = 32'sh4000_0000;
      o.quat_x = near(1 << 26);
      o.quat_y = near(1 << 26);
      o.quat_z = near(1 << 26);
    end
    o.trans_x = near(1 << 20);
    o.trans_y = near(1 << 20);
    o.trans_z = near(1 << 22);
    o.point_x = near(1 << 22);
    o.point_y = near(1 << 22);
    o.point_z = near(1 << 23);
    o.obs_x = near(1 << 26);
    o.obs_y = near(1 << 26);
    return o;
  endfunction

  task automatic random_batch(int count);
    repeat (count) add_obs($urandom_range(0, 9) < 7 ? scene_obs() : wild_obs());
  endtask

  task automatic directed_set();
    rpr_in_t o;
    o = '0;
    add_obs(o);
    o = '1;
    add_obs(o);
    o = {12{32'sh7FFF_FFFF}};
    add_obs(o);
    o = {12{32'sh8000_0000}};
    add_obs(o);
    o = '0;
    o.quat_w = 32'sh4000_0000;
    o.point_z = 32'sh0001_0000;
    add_obs(o);
    o.point_z = -32'sh0001_0000;
    add_obs(o);
    o.point_x = 32'sh0002_0000;
    o.point_z = 32'sh0000_0001;
    add_obs(o);
    o.point_x = 32'sh0001_0000;
    o.point_y = -32'sh0001_0000;
    o.point_z = 0;
    add_obs(o);
    o.point_x = -32'sh0001_0000;
    o.point_y = 32'sh0001_0000;
    add_obs(o);
    o.point_z = 32'sh0000_8000;
    o.trans_z = -32'sh0000_8000;
    add_obs(o);
    o = scene_obs();
    o.quat_w = 0; o.quat_x = 0; o.quat_y = 0; o.quat_z = 0;
    add_obs(o);
    o = scene_obs();
    o.obs_x = 32'sh7FFF_FFFF;
    o.obs_y = 32'sh8000_0000;
    add_obs(o);
    o = scene_obs();
    o.quat_w = 0; o.quat_x = 32'sh4000_0000; o.quat_y = 0; o.quat_z = 0;
    add_obs(o);
    o.quat_x = 0; o.quat_y = 32'sh4000_0000;
    add_obs(o);
    o.quat_y = 0; o.quat_z = 32'sh4000_0000;
    add_obs(o);
    repeat (5) add_obs(wild_obs());
  endtask

  initial begin
    rst = 1;
    obs_valid = 0;
    obs = '0;
    res_stall = 0;
    cfg_we = 0;
    cfg_index = CFG_FOCAL_X;
    cfg_data = '0;
    focal_x_q = FOCAL_RESET;
    focal_y_q = FOCAL_RESET;
    center_x_q = 0;
    center_y_q = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    directed_set();
    random_batch(130);
    drain();

    write_cfg(CFG_FOCAL_X, 32'h7FFF_FFFF);
    write_cfg(CFG_FOCAL_Y, 32'hFFFF_FFFF);
    write_cfg(CFG_PRINCIPAL_X, 32'h8000_0000);
    write_cfg(CFG_PRINCIPAL_Y, 32'h7FFF_FFFF);
    directed_set();
    random_batch(80);
    drain();

    write_cfg(CFG_FOCAL_X, 32'h0);
    write_cfg(CFG_FOCAL_Y, 32'h0);
    write_cfg(CFG_PRINCIPAL_X, 32'h7FFF_FFFF);
    write_cfg(CFG_PRINCIPAL_Y, 32'h8000_0000);
    random_batch(60);
    drain();

    write_cfg(CFG_FOCAL_X, 32'h0258_0000);
    write_cfg(CFG_FOCAL_Y, 32'h0190_8000);
    write_cfg(CFG_PRINCIPAL_X, 32'h0140_0000);
    write_cfg(CFG_PRINCIPAL_Y, 32'h00F0_0000);
    // hold the output while beats keep coming, so the pipe fills up
    calm = 1;
    @(negedge clk);
    hold_req = 1;
    random_batch(120);
    drain();
    calm = 0;
    random_batch(200);
    drain();

    $display("covered %0d observations in four config settings, %0d results checked",
             obs_sent, res_seen);
    $display("%0d zero-depth results, %0d clipped results, %0d mismatches",
             zero_depth_seen, clipped_seen, mismatches);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_div.sv
hw/rtl/reprojection_residual.sv
tb/reprojection_residual_tb.sv
